>>> sv/cms_pkg.sv
// Shared types and constants for the current monitor statistics block.
package cms_pkg;

    localparam int RAW_W     = 16;
    localparam int CUR_W     = 16;
    localparam int FLOOR_W   = 17;
    localparam int MEAN_W    = 16;
    localparam int SUM_W     = 48;
    localparam int OUT_CNT_W = 32;
    localparam int CH_SLOTS  = 2;
    localparam int STEP_W    = $clog2(MEAN_W);

    typedef enum logic [1:0] {
        K_SAMPLE = 2'd0,
        K_FAIL   = 2'd1,
        K_CLEAR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               in_range;
        logic               channel;
        logic [RAW_W-1:0]   shunt;
        logic [RAW_W-1:0]   bus;
        logic [CUR_W-1:0]   mag;
    } t_cmd;

endpackage

>>> sv/current_monitor_statistics.sv
// Top level of the current monitor statistics block.
//
//  channel   direction  handshake         payload
//  input     in         push / full       op, channel, read_failed, shunt_raw, bus_raw
//  result    out        empty / pop       out_channel .. samples_taken
//
// A counted sample holds the back end in S_DIV while the serial divider forms
// the mean, one quotient bit per cycle; the back end then moves to S_SEND and
// loads the result register. Other items go from S_IDLE straight to S_SEND.
// Reset is synchronous and returns every channel to its cleared statistics.
// A two-entry input queue keeps taking items while the back end works, until it
// is full, and a waiting result blocks only the back end.
module current_monitor_statistics import cms_pkg::*; #(
    parameter int CHANNELS   = 2,
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_op,
    input  logic                  i_channel,
    input  logic                  i_read_failed,
    input  logic signed [RAW_W-1:0] i_shunt_raw,
    input  logic [RAW_W-1:0]      i_bus_raw,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_out_channel,
    output logic                  o_sample_valid,
    output logic signed [RAW_W-1:0] o_last_shunt,
    output logic [RAW_W-1:0]      o_last_bus,
    output logic [CUR_W-1:0]      o_current_now,
    output logic [CUR_W-1:0]      o_current_peak,
    output logic [FLOOR_W-1:0]    o_current_floor,
    output logic [MEAN_W-1:0]     o_current_mean,
    output logic [RAW_W-1:0]      o_bus_floor,
    output logic [OUT_CNT_W-1:0]  o_samples_taken
);

    logic             w_cmd_valid;
    t_cmd             w_cmd;
    logic             w_cmd_pop;
    logic             w_out_valid;
    logic [RAW_W-1:0] w_last_shunt;

    cms_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_read_failed (i_read_failed),
        .i_shunt_raw   (i_shunt_raw),
        .i_bus_raw     (i_bus_raw),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    cms_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .o_out_valid     (w_out_valid),
        .i_out_pop       (pop && w_out_valid),
        .o_out_channel   (o_out_channel),
        .o_sample_valid  (o_sample_valid),
        .o_last_shunt    (w_last_shunt),
        .o_last_bus      (o_last_bus),
        .o_current_now   (o_current_now),
        .o_current_peak  (o_current_peak),
        .o_current_floor (o_current_floor),
        .o_current_mean  (o_current_mean),
        .o_bus_floor     (o_bus_floor),
        .o_samples_taken (o_samples_taken)
    );

    assign empty        = !w_out_valid;
    assign o_last_shunt = w_last_shunt;

endmodule

>>> sv/cms_front.sv
// Front end: classifies input items and queues them for the back end.
module cms_front import cms_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_op,
    input  logic              i_channel,
    input  logic              i_read_failed,
    input  logic [RAW_W-1:0]  i_shunt_raw,
    input  logic [RAW_W-1:0]  i_bus_raw,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd       r_mem [CH_SLOTS];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_cmd.channel  = i_channel;
        w_cmd.in_range = (CHANNELS > 1) || (i_channel == 1'b0);
        w_cmd.shunt    = i_shunt_raw;
        w_cmd.bus      = i_bus_raw;
        w_cmd.mag      = i_shunt_raw[RAW_W-1] ? (CUR_W'(0) - i_shunt_raw) : i_shunt_raw;
        if (i_op) begin
            w_cmd.kind = K_CLEAR;
        end else if (i_read_failed) begin
            w_cmd.kind = K_FAIL;
        end else begin
            w_cmd.kind = K_SAMPLE;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> sv/cms_div.sv
// Restoring serial divider: sum over count, one quotient bit per cycle.
module cms_div import cms_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_W-1:0]      i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [MEAN_W-1:0]     o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [MEAN_W-1:0]     r_low;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_q;
    logic [COUNT_BITS-1:0] w_rem_next;

    // quotient always fits in MEAN_W bits, so the upper dividend bits start below the divisor
    always_comb begin
        w_trial    = {r_rem, r_low[MEAN_W-1]};
        w_diff     = w_trial - {1'b0, r_div};
        w_q        = (w_trial >= {1'b0, r_div});
        w_rem_next = w_q ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(MEAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[MEAN_W +: COUNT_BITS];
            r_low <= i_dividend[MEAN_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_low <= {r_low[MEAN_W-2:0], w_q};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule

>>> sv/cms_back.sv
// Back end: per-channel statistics, mean update and result register.
module cms_back import cms_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_pop,
    output logic                 o_out_channel,
    output logic                 o_sample_valid,
    output logic [RAW_W-1:0]     o_last_shunt,
    output logic [RAW_W-1:0]     o_last_bus,
    output logic [CUR_W-1:0]     o_current_now,
    output logic [CUR_W-1:0]     o_current_peak,
    output logic [FLOOR_W-1:0]   o_current_floor,
    output logic [MEAN_W-1:0]    o_current_mean,
    output logic [RAW_W-1:0]     o_bus_floor,
    output logic [OUT_CNT_W-1:0] o_samples_taken
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state                r_state;
    logic                  r_ch;
    logic                  r_in_range;

    logic                  r_valid     [CH_SLOTS];
    logic [RAW_W-1:0]      r_shunt     [CH_SLOTS];
    logic [RAW_W-1:0]      r_bus       [CH_SLOTS];
    logic [CUR_W-1:0]      r_cur       [CH_SLOTS];
    logic [CUR_W-1:0]      r_peak      [CH_SLOTS];
    logic [FLOOR_W-1:0]    r_floor     [CH_SLOTS];
    logic [MEAN_W-1:0]     r_mean      [CH_SLOTS];
    logic [SUM_W-1:0]      r_sum       [CH_SLOTS];
    logic [RAW_W-1:0]      r_bfloor    [CH_SLOTS];
    logic [COUNT_BITS-1:0] r_count     [CH_SLOTS];

    logic                  r_out_valid;
    logic                  r_out_channel;
    logic                  r_out_sample_valid;
    logic [RAW_W-1:0]      r_out_shunt;
    logic [RAW_W-1:0]      r_out_bus;
    logic [CUR_W-1:0]      r_out_now;
    logic [CUR_W-1:0]      r_out_peak;
    logic [FLOOR_W-1:0]    r_out_floor;
    logic [MEAN_W-1:0]     r_out_mean;
    logic [RAW_W-1:0]      r_out_bfloor;
    logic [OUT_CNT_W-1:0]  r_out_count;

    logic                  w_take;
    logic                  w_counting;
    logic                  w_div_start;
    logic [SUM_W:0]        w_sum_add;
    logic [SUM_W-1:0]      n_sum;
    logic [COUNT_BITS-1:0] n_count;
    logic                  w_div_done;
    logic [MEAN_W-1:0]     w_quotient;
    logic                  w_load;
    logic [OUT_CNT_W-1:0]  w_count_ext;

    assign w_take      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop   = w_take;
    assign w_counting  = (r_count[i_cmd.channel] != {COUNT_BITS{1'b1}});
    assign w_div_start = w_take && (i_cmd.kind == K_SAMPLE) && i_cmd.in_range && w_counting;
    assign w_sum_add   = {1'b0, r_sum[i_cmd.channel]} + (SUM_W + 1)'(i_cmd.mag);
    assign n_sum       = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];
    assign n_count     = r_count[i_cmd.channel] + COUNT_BITS'(1);
    assign w_load      = (r_state == S_SEND) && (!r_out_valid || i_out_pop);

    cms_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ch       <= 1'b0;
            r_in_range <= 1'b0;
            for (int c = 0; c < CH_SLOTS; c++) begin
                r_valid[c]  <= 1'b0;
                r_shunt[c]  <= '0;
                r_bus[c]    <= '0;
                r_cur[c]    <= '0;
                r_peak[c]   <= '0;
                r_floor[c]  <= '1;
                r_mean[c]   <= '0;
                r_sum[c]    <= '0;
                r_bfloor[c] <= '1;
                r_count[c]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_ch       <= i_cmd.channel;
                        r_in_range <= i_cmd.in_range;
                        r_state    <= w_div_start ? S_DIV : S_SEND;
                        case (i_cmd.kind)
                            K_CLEAR: begin
                                for (int c = 0; c < CH_SLOTS; c++) begin
                                    r_valid[c]  <= 1'b0;
                                    r_shunt[c]  <= '0;
                                    r_bus[c]    <= '0;
                                    r_cur[c]    <= '0;
                                    r_peak[c]   <= '0;
                                    r_floor[c]  <= '1;
                                    r_mean[c]   <= '0;
                                    r_sum[c]    <= '0;
                                    r_bfloor[c] <= '1;
                                    r_count[c]  <= '0;
                                end
                            end
                            K_FAIL: begin
                                if (i_cmd.in_range) begin
                                    r_valid[i_cmd.channel] <= 1'b0;
                                end
                            end
                            K_SAMPLE: begin
                                if (i_cmd.in_range) begin
                                    r_valid[i_cmd.channel] <= 1'b1;
                                    r_shunt[i_cmd.channel] <= i_cmd.shunt;
                                    r_bus[i_cmd.channel]   <= i_cmd.bus;
                                    r_cur[i_cmd.channel]   <= i_cmd.mag;
                                    if (i_cmd.mag > r_peak[i_cmd.channel]) begin
                                        r_peak[i_cmd.channel] <= i_cmd.mag;
                                    end
                                    if (FLOOR_W'(i_cmd.mag) < r_floor[i_cmd.channel]) begin
                                        r_floor[i_cmd.channel] <= FLOOR_W'(i_cmd.mag);
                                    end
                                    if (i_cmd.bus < r_bfloor[i_cmd.channel]) begin
                                        r_bfloor[i_cmd.channel] <= i_cmd.bus;
                                    end
                                    if (w_counting) begin
                                        r_sum[i_cmd.channel]   <= n_sum;
                                        r_count[i_cmd.channel] <= n_count;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mean[r_ch] <= w_quotient;
                        r_state      <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        w_count_ext = '0;
        w_count_ext[COUNT_BITS-1:0] = r_count[r_ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_channel <= r_ch;
            if (r_in_range) begin
                r_out_sample_valid <= r_valid[r_ch];
                r_out_shunt        <= r_shunt[r_ch];
                r_out_bus          <= r_bus[r_ch];
                r_out_now          <= r_cur[r_ch];
                r_out_peak         <= r_peak[r_ch];
                r_out_floor        <= r_floor[r_ch];
                r_out_mean         <= r_mean[r_ch];
                r_out_bfloor       <= r_bfloor[r_ch];
                r_out_count        <= w_count_ext;
            end else begin
                r_out_sample_valid <= 1'b0;
                r_out_shunt        <= '0;
                r_out_bus          <= '0;
                r_out_now          <= '0;
                r_out_peak         <= '0;
                r_out_floor        <= '0;
                r_out_mean         <= '0;
                r_out_bfloor       <= '0;
                r_out_count        <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_channel   = r_out_channel;
    assign o_sample_valid  = r_out_sample_valid;
    assign o_last_shunt    = r_out_shunt;
    assign o_last_bus      = r_out_bus;
    assign o_current_now   = r_out_now;
    assign o_current_peak  = r_out_peak;
    assign o_current_floor = r_out_floor;
    assign o_current_mean  = r_out_mean;
    assign o_bus_floor     = r_out_bfloor;
    assign o_samples_taken = r_out_count;

endmodule

>>> dv/tb_current_monitor_statistics.sv
// Testbench for current_monitor_statistics: directed and random items checked against a predictor.
module tb_current_monitor_statistics;
    import cms_pkg::*;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;
    localparam logic [FLOOR_W-1:0]   FLOOR_ONES  = '1;
    localparam logic [RAW_W-1:0]     BUS_ONES    = '1;
    localparam logic [SUM_W-1:0]     SUM_TOP     = '1;
    localparam logic [OUT_CNT_W-1:0] COUNT_TOP   = '1;
    localparam int                   STALL_LIMIT = 3000;
    localparam int                   SETTLE_CYCLES = 64;

    typedef struct {
        logic                 out_ch;
        logic                 valid;
        logic [RAW_W-1:0]     shunt;
        logic [RAW_W-1:0]     bus;
        logic [CUR_W-1:0]     now;
        logic [CUR_W-1:0]     peak;
        logic [FLOOR_W-1:0]   low;
        logic [MEAN_W-1:0]    mean;
        logic [RAW_W-1:0]     bus_low;
        logic [OUT_CNT_W-1:0] count;
    } t_stats;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   i_op = 1'b0;
    logic                   i_channel = 1'b0;
    logic                   i_read_failed = 1'b0;
    logic signed [RAW_W-1:0] i_shunt_raw = '0;
    logic [RAW_W-1:0]       i_bus_raw = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   o_out_channel;
    logic                   o_sample_valid;
    logic signed [RAW_W-1:0] o_last_shunt;
    logic [RAW_W-1:0]       o_last_bus;
    logic [CUR_W-1:0]       o_current_now;
    logic [CUR_W-1:0]       o_current_peak;
    logic [FLOOR_W-1:0]     o_current_floor;
    logic [MEAN_W-1:0]      o_current_mean;
    logic [RAW_W-1:0]       o_bus_floor;
    logic [OUT_CNT_W-1:0]   o_samples_taken;

    // per-channel statistics as predicted
    logic                   valid_flag [CH_SLOTS];
    logic [RAW_W-1:0]       shunt_last [CH_SLOTS];
    logic [RAW_W-1:0]       bus_last   [CH_SLOTS];
    logic [FLOOR_W-1:0]     cur_last   [CH_SLOTS];
    logic [FLOOR_W-1:0]     cur_peak   [CH_SLOTS];
    logic [FLOOR_W-1:0]     cur_low    [CH_SLOTS];
    logic [FLOOR_W-1:0]     cur_mean   [CH_SLOTS];
    logic [SUM_W-1:0]       cur_sum    [CH_SLOTS];
    logic [RAW_W-1:0]       bus_low    [CH_SLOTS];
    logic [OUT_CNT_W-1:0]   good_count [CH_SLOTS];

    t_stats expected_stats [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;
    int n_samples = 0;
    int n_failed = 0;
    int n_clears = 0;
    int n_checked = 0;

    current_monitor_statistics #(
        .CHANNELS   (2),
        .COUNT_BITS (32)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_read_failed   (i_read_failed),
        .i_shunt_raw     (i_shunt_raw),
        .i_bus_raw       (i_bus_raw),
        .empty           (empty),
        .pop             (pop),
        .o_out_channel   (o_out_channel),
        .o_sample_valid  (o_sample_valid),
        .o_last_shunt    (o_last_shunt),
        .o_last_bus      (o_last_bus),
        .o_current_now   (o_current_now),
        .o_current_peak  (o_current_peak),
        .o_current_floor (o_current_floor),
        .o_current_mean  (o_current_mean),
        .o_bus_floor     (o_bus_floor),
        .o_samples_taken (o_samples_taken)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_stats();
        for (int c = 0; c < CH_SLOTS; c++) begin
            valid_flag[c] = 1'b0;
            shunt_last[c] = '0;
            bus_last[c]   = '0;
            cur_last[c]   = '0;
            cur_peak[c]   = '0;
            cur_low[c]    = FLOOR_ONES;
            cur_mean[c]   = '0;
            cur_sum[c]    = '0;
            bus_low[c]    = BUS_ONES;
            good_count[c] = '0;
        end
    endfunction

    function automatic t_stats apply_item(logic op, logic ch, logic failed,
                                          logic [RAW_W-1:0] shunt, logic [RAW_W-1:0] bus);
        t_stats r;
        logic [FLOOR_W-1:0] mag;
        logic [SUM_W-1:0] quot;
        if (op == OP_CLEAR) begin
            clear_stats();
        end else if (failed) begin
            valid_flag[ch] = 1'b0;
        end else begin
            mag = shunt[RAW_W-1] ? ({1'b0, ~shunt} + 1'b1) : {1'b0, shunt};
            shunt_last[ch] = shunt;
            bus_last[ch]   = bus;
            cur_last[ch]   = mag;
            valid_flag[ch] = 1'b1;
            if (good_count[ch] != COUNT_TOP) begin
                good_count[ch] = good_count[ch] + 1'b1;
                cur_sum[ch] = (cur_sum[ch] > SUM_TOP - mag) ? SUM_TOP : cur_sum[ch] + mag;
                quot = cur_sum[ch] / good_count[ch];
                cur_mean[ch] = (quot > FLOOR_ONES) ? FLOOR_ONES : quot[FLOOR_W-1:0];
            end
            if (mag > cur_peak[ch]) cur_peak[ch] = mag;
            if (mag < cur_low[ch]) cur_low[ch] = mag;
            if (bus < bus_low[ch]) bus_low[ch] = bus;
        end
        r.out_ch  = ch;
        r.valid   = valid_flag[ch];
        r.shunt   = shunt_last[ch];
        r.bus     = bus_last[ch];
        r.now     = cur_last[ch][CUR_W-1:0];
        r.peak    = cur_peak[ch][CUR_W-1:0];
        r.low     = cur_low[ch];
        r.mean    = cur_mean[ch][MEAN_W-1:0];
        r.bus_low = bus_low[ch];
        r.count   = good_count[ch];
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] pick_reading();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return RAW_W'($urandom_range(31));
            5: return ~RAW_W'($urandom_range(31));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op, logic ch, logic failed,
                             logic [RAW_W-1:0] shunt, logic [RAW_W-1:0] bus);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_channel     <= ch;
        i_read_failed <= failed;
        i_shunt_raw   <= shunt;
        i_bus_raw     <= bus;
        do @(posedge i_clk); while (full);
        expected_stats.push_back(apply_item(op, ch, failed, shunt, bus));
        if (op == OP_CLEAR) n_clears++;
        else if (failed) n_failed++;
        else n_samples++;
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(99);
        send_item((r < 2) ? OP_CLEAR : OP_SAMPLE, 1'($urandom), (r >= 2 && r < 12),
                  pick_reading(), pick_reading());
    endtask

    task automatic test_reading_extremes();
        send_item(OP_CLEAR,  1'b0, 1'b0, 16'h1357, 16'h2468);
        send_item(OP_SAMPLE, 1'b0, 1'b1, 16'h0100, 16'h0200);  // failed read, never sampled
        send_item(OP_SAMPLE, 1'b0, 1'b0, 16'h0000, 16'h1234);
        send_item(OP_SAMPLE, 1'b0, 1'b0, 16'h7FFF, 16'hFFFF);
        send_item(OP_SAMPLE, 1'b0, 1'b0, 16'h8000, 16'h0000);
        send_item(OP_SAMPLE, 1'b0, 1'b0, 16'hFFFF, 16'h0064);
        send_item(OP_SAMPLE, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'h0001, 16'hFFFF);
        send_item(OP_SAMPLE, 1'b1, 1'b1, 16'h4000, 16'h0001);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'h8001, 16'hFFFE);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'h5555, 16'hAAAA);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'hAAAA, 16'h5555);
        send_item(OP_SAMPLE, 1'b0, 1'b0, 16'h0001, 16'h0001);
        send_item(OP_CLEAR,  1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, 1'b0, 1'b1, 16'h7FFF, 16'h0000);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'h8000, 16'h8000);
        send_item(OP_SAMPLE, 1'b1, 1'b0, 16'h0000, 16'h7FFF);
        send_item(OP_CLEAR,  1'b0, 1'b0, 16'h0000, 16'h0000);
        finish_phase();
    endtask

    task automatic test_random_traffic(int n);
        repeat (n) send_random_item();
        finish_phase();
    endtask

    task automatic test_full_stall();
        hold_left = 300;
        repeat (40) send_random_item();
        finish_phase();
    endtask

    // result side
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_stats want;
        t_stats got;
        if (i_rst_n && pop && !empty) begin
            got.out_ch  = o_out_channel;
            got.valid   = o_sample_valid;
            got.shunt   = o_last_shunt;
            got.bus     = o_last_bus;
            got.now     = o_current_now;
            got.peak    = o_current_peak;
            got.low     = o_current_floor;
            got.mean    = o_current_mean;
            got.bus_low = o_bus_floor;
            got.count   = o_samples_taken;
            if (expected_stats.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual channel %0d count %0h",
                         $time, got.out_ch, got.count);
            end else begin
                want = expected_stats.pop_front();
                n_checked++;
                check_field("out_channel",   want.out_ch,  got.out_ch);
                check_field("sample_valid",  want.valid,   got.valid);
                check_field("last_shunt",    want.shunt,   got.shunt);
                check_field("last_bus",      want.bus,     got.bus);
                check_field("current_now",   want.now,     got.now);
                check_field("current_peak",  want.peak,    got.peak);
                check_field("current_floor", want.low,     got.low);
                check_field("current_mean",  want.mean,    got.mean);
                check_field("bus_floor",     want.bus_low, got.bus_low);
                check_field("samples_taken", want.count,   got.count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clear_stats();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 86;
        test_reading_extremes();
        test_random_traffic(500);

        send_idle_pct = 86;
        recv_idle_pct = 33;
        test_random_traffic(500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_stall();
        test_random_traffic(490);

        $display("Ran %0d good samples, %0d failed reads and %0d clears over %0d channels,",
                 n_samples, n_failed, n_clears, CH_SLOTS);
        $display("with both sides stalling and a full input queue; %0d results checked, %0d errors",
                 n_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/cms_pkg.sv
sv/cms_front.sv
sv/cms_div.sv
sv/cms_back.sv
sv/current_monitor_statistics.sv
dv/tb_current_monitor_statistics.sv
